@@ hdl/arh_pkg.sv @@
// arh_pkg: shared types and constants for the auto-ranged histogram
// no dependencies
`timescale 1ns / 1ps
package arh_pkg;

  localparam int unsigned NumBinsReset = 50;

  typedef struct packed {
    logic [31:0] sample;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  bin_index;
    logic [10:0] bin_count;
    logic [31:0] data_min;
    logic [31:0] data_max;
    logic        overflowed;
    logic        last_bin;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // store a sample, update min/max
    logic clr_bins;   // clear one bin count at bin_ptr
    logic rd_req;     // read sample at smp_ptr
    logic div_start;  // start a scaled quotient
    logic bin_inc;    // fetch the count of the quotient's bin
    logic bin_wr;     // write back the fetched count plus one
    logic bin_rd;     // fetch the count at bin_ptr for output
    logic set_clear;  // restore set state
  } arh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
  } arh_sts_t;

endpackage

@@ hdl/arh_datapath.sv @@
// arh_datapath: sample store, min/max tracking, serial scaled divider, bin counters
// depends on arh_pkg
`timescale 1ns / 1ps
module arh_datapath #(
  parameter int unsigned MaxSamples = 1024,
  parameter int unsigned MaxBins    = 64,
  parameter int unsigned SampleBits = 32,
  localparam int unsigned AddrW     = (MaxSamples > 1) ? $clog2(MaxSamples) : 1,
  localparam int unsigned CntW      = $clog2(MaxSamples + 1),
  localparam int unsigned BinW      = (MaxBins > 1) ? $clog2(MaxBins) : 1,
  localparam int unsigned NbW       = $clog2(MaxBins + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  arh_pkg::arh_cmd_t   cmd_i,
  input  logic [31:0]         sample_i,
  input  logic [AddrW-1:0]    smp_ptr_i,
  input  logic [BinW-1:0]     bin_ptr_i,
  input  logic [NbW-1:0]      nb_i,
  output arh_pkg::arh_sts_t   sts_o,
  output logic [CntW-1:0]     count_o,
  output logic [10:0]         bin_count_o,
  output logic [31:0]         data_min_o,
  output logic [31:0]         data_max_o,
  output logic                overflowed_o
);

  logic [SampleBits-1:0] store_mem [MaxSamples];
  logic [SampleBits-1:0] rd_data_q;
  logic [SampleBits-1:0] smp;
  logic [CntW-1:0]       count_q;
  logic [SampleBits-1:0] min_q, max_q;
  logic                  ovf_q;
  logic [10:0]           bins_mem [MaxBins];
  logic [10:0]           bin_rd_q;
  logic [BinW-1:0]       bin_addr_q;

  // serial scaled quotient: one bin step per cycle
  logic [SampleBits:0]   rem_q;
  logic [SampleBits-1:0] gap_q, d_q;
  logic [NbW-1:0]        q_q, step_q;
  logic                  div_busy_q, div_done_q;
  logic [SampleBits-1:0] range;
  logic [BinW-1:0]       bin_sel;

  assign smp = SampleBits'(sample_i);
  assign range = max_q - min_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CntW'(MaxSamples))) begin
      store_mem[count_q[AddrW-1:0]] <= smp;
    end
    if (cmd_i.rd_req) begin
      rd_data_q <= store_mem[smp_ptr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.set_clear) begin
      count_q <= '0;
      min_q   <= '1;
      max_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (count_q < CntW'(MaxSamples)) begin
        count_q <= count_q + 1'b1;
        if (smp < min_q) min_q <= smp;
        if (smp > max_q) max_q <= smp;
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      rem_q      <= '0;
      gap_q      <= '0;
      d_q        <= '0;
      q_q        <= '0;
      step_q     <= '0;
    end else begin
      div_done_q <= 1'b0;
      if (cmd_i.div_start) begin
        d_q        <= rd_data_q - min_q;
        gap_q      <= range - (rd_data_q - min_q);
        rem_q      <= '0;
        q_q        <= '0;
        step_q     <= '0;
        div_busy_q <= 1'b1;
      end else if (div_busy_q) begin
        if (step_q == nb_i || range == '0) begin
          div_busy_q <= 1'b0;
          div_done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
          if (rem_q >= {1'b0, gap_q}) begin
            rem_q <= rem_q - {1'b0, gap_q};
            q_q   <= q_q + 1'b1;
          end else begin
            rem_q <= rem_q + {1'b0, d_q};
          end
        end
      end
    end
  end

  always_comb begin
    if (range == '0) bin_sel = '0;
    else if (q_q >= nb_i) bin_sel = BinW'(nb_i - 1'b1);
    else bin_sel = BinW'(q_q);
  end

  // bin counts: one registered read and one write per cycle, cleared by each run
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_bins) begin
      bins_mem[bin_ptr_i] <= '0;
    end else if (cmd_i.bin_wr) begin
      bins_mem[bin_addr_q] <= bin_rd_q + 1'b1;
    end
    if (cmd_i.bin_inc) begin
      bin_rd_q   <= bins_mem[bin_sel];
      bin_addr_q <= bin_sel;
    end else if (cmd_i.bin_rd) begin
      bin_rd_q <= bins_mem[bin_ptr_i];
    end
  end

  assign sts_o.div_done = div_done_q;
  assign count_o        = count_q;
  assign bin_count_o    = bin_rd_q;
  assign data_min_o     = 32'(min_q);
  assign data_max_o     = 32'(max_q);
  assign overflowed_o   = ovf_q;

  bin_clear_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bin_inc |-> (NbW'(bin_sel) < nb_i)) else $error("bin out of range");
  min_le_max_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q)) else $error("min above max");
  count_cap_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxSamples)) else $error("count overflow");

endmodule

@@ hdl/arh_ctrl.sv @@
// arh_ctrl: sequencer for load, bin clear, binning pass and result output
// depends on arh_pkg
`timescale 1ns / 1ps
module arh_ctrl #(
  parameter int unsigned MaxSamples = 1024,
  parameter int unsigned MaxBins    = 64,
  localparam int unsigned AddrW     = (MaxSamples > 1) ? $clog2(MaxSamples) : 1,
  localparam int unsigned CntW      = $clog2(MaxSamples + 1),
  localparam int unsigned BinW      = (MaxBins > 1) ? $clog2(MaxBins) : 1,
  localparam int unsigned NbW       = $clog2(MaxBins + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               last_i,
  input  arh_pkg::arh_sts_t  sts_i,
  input  logic [CntW-1:0]    count_i,
  input  logic [NbW-1:0]     nb_i,
  output arh_pkg::arh_cmd_t  cmd_o,
  output logic [AddrW-1:0]   smp_ptr_o,
  output logic [BinW-1:0]    bin_ptr_o,
  output logic               busy_o,
  output logic               strobe_o,
  output logic               last_bin_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_READ, S_START, S_DIV, S_INC, S_FETCH, S_EMIT, S_DONE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] ptr_q;
  logic [BinW-1:0] bin_q;
  logic            emit;

  assign emit = (state_q == S_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      bin_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i && last_i) begin
            state_q <= S_CLR;
            bin_q   <= '0;
          end
        end
        S_CLR: begin
          if (bin_q == BinW'(MaxBins - 1)) begin
            state_q <= S_READ;
            ptr_q   <= '0;
          end
          bin_q <= bin_q + 1'b1;
        end
        S_READ:  state_q <= S_START;
        S_START: state_q <= S_DIV;
        S_DIV: begin
          if (sts_i.div_done) state_q <= S_INC;
        end
        S_INC: begin
          if (ptr_q + 1'b1 >= count_i) begin
            state_q <= S_FETCH;
            bin_q   <= '0;
          end else begin
            state_q <= S_READ;
          end
          ptr_q <= ptr_q + 1'b1;
        end
        S_FETCH: state_q <= S_EMIT;
        S_EMIT: begin
          if (NbW'(bin_q) + 1'b1 >= nb_i) state_q <= S_DONE;
          else state_q <= S_FETCH;
          bin_q <= bin_q + 1'b1;
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = start_i && (state_q == S_IDLE);
    cmd_o.clr_bins  = (state_q == S_CLR);
    cmd_o.rd_req    = (state_q == S_READ);
    cmd_o.div_start = (state_q == S_START);
    cmd_o.bin_inc   = (state_q == S_DIV) && sts_i.div_done;
    cmd_o.bin_wr    = (state_q == S_INC);
    cmd_o.bin_rd    = (state_q == S_FETCH);
    cmd_o.set_clear = (state_q == S_DONE);
  end

  assign smp_ptr_o  = ptr_q[AddrW-1:0];
  assign bin_ptr_o  = bin_q;
  assign busy_o     = (state_q != S_IDLE);
  assign strobe_o   = emit;
  assign last_bin_o = emit && (NbW'(bin_q) + 1'b1 >= nb_i);

  no_load_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd_o.load) else $error("load while busy");
  emit_after_last_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_bin_o |=> (state_q == S_DONE)) else $error("emit did not end");
  strobe_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy_o) else $error("strobe while idle");

endmodule

@@ hdl/auto_range_histogram.sv @@
// auto_range_histogram: top level, config register and controller/datapath wiring
// depends on arh_pkg, arh_ctrl, arh_datapath
`timescale 1ns / 1ps
// Usage: drive in_i with start high while busy is low; each accepted item
// stores one sample and updates the running min and max in that cycle, so the
// items of a set can follow back to back, one per cycle.
// An item with last_sample set starts the binning run and busy rises on the
// next cycle: the counts of all MaxBins bins are cleared, then each stored
// sample is read, run through a serial scaled-quotient unit (which gives
// bin 0 when all samples are equal) and added to its bin, one after another.
// Then one result per bin is shown on out_o with strobe high for one cycle,
// each after its count is fetched, bins in ascending order, last_bin set on
// the final one; busy stays high through the done state that follows it. The
// receiver cannot stall; results must be taken as
// they appear. num_bins is written on the cfg channel (cfg_valid_i,
// cfg_ready_o, cfg_data_i), ready only while idle; 0 acts as 1, values above
// MaxBins as MaxBins. Reset sets num_bins to 50 and empties the data set; bin
// counts are cleared by every run and the sample store needs no clearing.
// Samples past MaxSamples are dropped and flagged.
module auto_range_histogram #(
  parameter int unsigned MaxSamples = 1024,
  parameter int unsigned MaxBins    = 64,
  parameter int unsigned SampleBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  arh_pkg::in_item_t  in_i,
  output logic               strobe,
  output arh_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);

  localparam int unsigned AddrW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned BinW  = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned NbW   = $clog2(MaxBins + 1);

  logic [6:0]        nb_reg_q;
  logic [NbW-1:0]    nb;
  arh_pkg::arh_cmd_t cmd;
  arh_pkg::arh_sts_t sts;
  logic [CntW-1:0]   count;
  logic [AddrW-1:0]  smp_ptr;
  logic [BinW-1:0]   bin_ptr;
  logic [10:0]       bin_count;
  logic [31:0]       dmin, dmax;
  logic              ovf, last_bin;

  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_reg_q <= 7'(arh_pkg::NumBinsReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      nb_reg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (nb_reg_q == '0) nb = NbW'(1);
    else if (32'(nb_reg_q) > MaxBins) nb = NbW'(MaxBins);
    else nb = NbW'(nb_reg_q);
  end

  arh_ctrl #(.MaxSamples(MaxSamples), .MaxBins(MaxBins)) u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .last_i(in_i.last_sample),
    .sts_i(sts), .count_i(count), .nb_i(nb),
    .cmd_o(cmd), .smp_ptr_o(smp_ptr), .bin_ptr_o(bin_ptr),
    .busy_o(busy), .strobe_o(strobe), .last_bin_o(last_bin)
  );

  arh_datapath #(.MaxSamples(MaxSamples), .MaxBins(MaxBins), .SampleBits(SampleBits))
  u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .sample_i(in_i.sample), .smp_ptr_i(smp_ptr), .bin_ptr_i(bin_ptr),
    .nb_i(nb), .sts_o(sts), .count_o(count), .bin_count_o(bin_count),
    .data_min_o(dmin), .data_max_o(dmax), .overflowed_o(ovf)
  );

  always_comb begin
    out_o            = '0;
    out_o.bin_index  = 6'(bin_ptr);
    out_o.bin_count  = bin_count;
    out_o.data_min   = dmin;
    out_o.data_max   = dmax;
    out_o.overflowed = ovf;
    out_o.last_bin   = last_bin;
  end

endmodule
